FILE: hdl/sdtw_pkg.sv
// Shared types and constants of the spike delay timing wheel.
// Used by every module of the block; depends on nothing.
package sdtw_pkg;

	// Event pointers are always 7 bits; the null pointer ends every list.
	localparam int PTR_W = 7;
	localparam logic [PTR_W-1:0] PTR_NULL = 7'd127;

	localparam int TARGET_W = 16;
	localparam int HANDLER_W = 2;
	localparam int DELAY_W = 16;
	localparam int STEP_W = 16;
	localparam int RING_LEN_W = 9;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	// Rounding divider: (2*delay + dt) / (2*dt).
	localparam int NUM_W = 18;
	localparam int DEN_W = 17;
	localparam int QUOT_W = 16;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 1'b1;

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic kind;
		logic [TARGET_W-1:0] target_id;
		logic [HANDLER_W-1:0] handler_sel;
		logic [DELAY_W-1:0] delay_us;
	} in_word_t;

	typedef struct packed {
		logic event_valid;
		logic [TARGET_W-1:0] out_target;
		logic [HANDLER_W-1:0] out_handler;
		status_t status;
		logic last;
	} out_word_t;

	// One entry of the event pool.
	typedef struct packed {
		logic [PTR_W-1:0] next;
		logic [TARGET_W-1:0] target;
		logic [HANDLER_W-1:0] handler;
	} event_entry_t;

	// Write strobes of the event pool: whole entry or link field only.
	typedef struct packed {
		logic entry;
		logic link;
	} event_wr_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SLOT,
		S_ALLOC,
		S_INSERT,
		S_TICK_HEAD,
		S_WALK
	} state_t;

endpackage

FILE: hdl/sdtw_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sdtw_pkg for its widths.
module sdtw_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdtw_pkg::NUM_W-1:0]  dividend,
	input  logic [sdtw_pkg::DEN_W-1:0]  divisor,
	output logic                        done,
	output logic [sdtw_pkg::QUOT_W-1:0] quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [sdtw_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [sdtw_pkg::DEN_W-1:0]       rem_q;
	logic [sdtw_pkg::NUM_W-1:0]       num_q;
	logic [sdtw_pkg::DEN_W-1:0]       den_q;
	logic [sdtw_pkg::QUOT_W-1:0]      quot_q;
	logic [sdtw_pkg::DEN_W:0]         trial;
	logic                             fits;

	assign trial = {rem_q, num_q[sdtw_pkg::NUM_W-1]};
	assign fits = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			// Done pulses for one cycle after the final quotient bit.
			done_q <= !start && busy_q &&
				(cnt_q == sdtw_pkg::DIV_CNT_W'(sdtw_pkg::NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdtw_pkg::DIV_CNT_W'(sdtw_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The quotient never exceeds QUOT_W bits, so the bits shifted out on top are zero.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= sdtw_pkg::DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[sdtw_pkg::DEN_W-1:0];
			end
			num_q <= {num_q[sdtw_pkg::NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[sdtw_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quot_q;

endmodule

FILE: hdl/sdtw_slot_ram.sv
// Slot head memory: one list head pointer per wheel slot.
// One write port, one registered read port; depends on sdtw_pkg.
module sdtw_slot_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [sdtw_pkg::PTR_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [sdtw_pkg::PTR_W-1:0] rdata
);

	logic [sdtw_pkg::PTR_W-1:0] mem [DEPTH];
	logic [sdtw_pkg::PTR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/sdtw_event_ram.sv
// Event pool memory: link, target and handler of each event entry.
// The link field can be written alone; depends on sdtw_pkg.
module sdtw_event_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                    clk,
	input  sdtw_pkg::event_wr_t     we,
	input  logic [AW-1:0]           waddr,
	input  sdtw_pkg::event_entry_t  wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output sdtw_pkg::event_entry_t  rdata
);

	logic [sdtw_pkg::PTR_W-1:0]     mem_next [DEPTH];
	logic [sdtw_pkg::TARGET_W-1:0]  mem_target [DEPTH];
	logic [sdtw_pkg::HANDLER_W-1:0] mem_handler [DEPTH];
	sdtw_pkg::event_entry_t         rdata_q;

	always_ff @(posedge clk) begin
		if (we.entry || we.link) begin
			mem_next[waddr] <= wdata.next;
		end
		if (we.entry) begin
			mem_target[waddr] <= wdata.target;
			mem_handler[waddr] <= wdata.handler;
		end
		if (re) begin
			rdata_q.next <= mem_next[raddr];
			rdata_q.target <= mem_target[raddr];
			rdata_q.handler <= mem_handler[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/spike_delay_timing_wheel_top.sv
// Spike delay timing wheel, top level: sequencer, configuration and output register.
// Instantiates sdtw_divider, sdtw_slot_ram and sdtw_event_ram; depends on sdtw_pkg.
//
// This block queues spike events on a timing wheel of up to RING_MAX slots and
// an event pool of POOL_SIZE entries. A schedule word rounds its delay to whole
// time steps with an iterative divider (one quotient bit per cycle), adds the
// current slot, wraps once, and pushes the event at the head of that slot's
// list, taking a recycled entry first and a fresh one otherwise; it returns one
// word with status ok, pool full or delay too long. A tick word reads the
// current slot head, then walks its list through the event memory, delivering
// one event word per cycle while the output register is free (most recent
// first, last set on the final one); an empty slot gives one word with
// event_valid low. The drained entries go back to the recycle list and the
// current slot advances, wrapping at ring_length. One word is worked on at a
// time; a new word is taken as soon as the sequencer is idle, even while a
// finished result still waits in the output register. After reset the block
// clears all RING_MAX slot heads, one slot per cycle, and takes no input word
// meanwhile; configuration writes are taken at any time but are meant to be
// made while the block is idle.
module spike_delay_timing_wheel_top #(
	parameter int RING_MAX = 256,
	parameter int POOL_SIZE = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sdtw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdtw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sdtw_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sdtw_pkg::out_word_t              out_data
);

	localparam int CUR_W = $clog2(RING_MAX);
	localparam int EV_W = $clog2(POOL_SIZE);
	localparam int SUM_W = ((CUR_W > sdtw_pkg::QUOT_W) ? CUR_W : sdtw_pkg::QUOT_W) + 1;

	// Configuration registers.
	logic [sdtw_pkg::RING_LEN_W-1:0] ring_len_q;
	logic [sdtw_pkg::STEP_W-1:0]     step_q;

	// Sequencer and wheel state.
	sdtw_pkg::state_t             state_q, state_d;
	logic [CUR_W-1:0]             cur_q;
	logic [CUR_W-1:0]             clr_q;
	logic [sdtw_pkg::PTR_W-1:0]   recycle_q;
	logic [sdtw_pkg::PTR_W-1:0]   fresh_q;

	// Per-word working registers.
	sdtw_pkg::in_word_t           in_q;
	logic [CUR_W-1:0]             slot_q;
	logic                         over_q;
	logic                         from_recycle_q;
	logic [EV_W-1:0]              e_q;
	logic [sdtw_pkg::PTR_W-1:0]   head_q;
	logic [EV_W-1:0]              n_q;

	// Output register.
	logic                         out_valid_q;
	sdtw_pkg::out_word_t          out_q;

	// Memory and divider hookup.
	logic                         slot_we, slot_re;
	logic [CUR_W-1:0]             slot_waddr, slot_raddr;
	logic [sdtw_pkg::PTR_W-1:0]   slot_wdata, slot_rdata;
	sdtw_pkg::event_wr_t          ev_we;
	logic                         ev_re;
	logic [EV_W-1:0]              ev_waddr, ev_raddr;
	sdtw_pkg::event_entry_t       ev_wdata, ev_rdata;
	logic                         div_start, div_done;
	logic [sdtw_pkg::QUOT_W-1:0]  div_quot;
	logic [sdtw_pkg::NUM_W-1:0]   div_num;
	logic [sdtw_pkg::DEN_W-1:0]   div_den;
	logic [sdtw_pkg::STEP_W-1:0]  dt;

	// Derived control.
	logic                         in_fire, out_free, out_load;
	sdtw_pkg::out_word_t          out_next;
	logic [SUM_W-1:0]             len_eff, slot_sum, slot_wrap, cur_inc;
	logic [CUR_W-1:0]             cur_next;
	logic                         recycle_ok, fresh_ok, head_ok, next_ok, walk_last;

	assign in_ready = (state_q == sdtw_pkg::S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// A ring length of zero acts as one; anything above RING_MAX acts as RING_MAX.
	always_comb begin
		if (ring_len_q == '0) begin
			len_eff = SUM_W'(1);
		end else if (SUM_W'(ring_len_q) > SUM_W'(RING_MAX)) begin
			len_eff = SUM_W'(RING_MAX);
		end else begin
			len_eff = SUM_W'(ring_len_q);
		end
	end

	// Rounded step count is (2*delay + dt) / (2*dt); a zero step time acts as one.
	assign dt = (step_q == '0) ? sdtw_pkg::STEP_W'(1) : step_q;
	assign div_num = {1'b0, in_data.delay_us, 1'b0} + sdtw_pkg::NUM_W'(dt);
	assign div_den = {dt, 1'b0};

	// Target slot: one wrap around the ring; still out of range means too long.
	assign slot_sum = SUM_W'(cur_q) + SUM_W'(div_quot);
	assign slot_wrap = (slot_sum >= len_eff) ? (slot_sum - len_eff) : slot_sum;

	// Advance of the current slot; a shrunk ring wraps it to zero here as well.
	assign cur_inc = SUM_W'(cur_q) + SUM_W'(1);
	assign cur_next = (cur_inc >= len_eff) ? '0 : cur_inc[CUR_W-1:0];

	assign recycle_ok = (recycle_q < sdtw_pkg::PTR_W'(POOL_SIZE));
	assign fresh_ok = (fresh_q < sdtw_pkg::PTR_W'(POOL_SIZE));
	assign head_ok = (slot_rdata < sdtw_pkg::PTR_W'(POOL_SIZE));
	assign next_ok = (ev_rdata.next < sdtw_pkg::PTR_W'(POOL_SIZE));
	assign walk_last = !next_ok || (n_q == EV_W'(POOL_SIZE - 1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdtw_pkg::S_CLEAR: begin
				if (clr_q == CUR_W'(RING_MAX - 1)) begin
					state_d = sdtw_pkg::S_IDLE;
				end
			end
			sdtw_pkg::S_IDLE: begin
				if (in_fire) begin
					state_d = (in_data.kind == sdtw_pkg::KIND_TICK) ?
						sdtw_pkg::S_TICK_HEAD : sdtw_pkg::S_DIV;
				end
			end
			sdtw_pkg::S_DIV: begin
				if (div_done) begin
					state_d = sdtw_pkg::S_SLOT;
				end
			end
			sdtw_pkg::S_SLOT: begin
				state_d = sdtw_pkg::S_ALLOC;
			end
			sdtw_pkg::S_ALLOC: begin
				if (!over_q && (recycle_ok || fresh_ok)) begin
					state_d = sdtw_pkg::S_INSERT;
				end else if (out_free) begin
					state_d = sdtw_pkg::S_IDLE;
				end
			end
			sdtw_pkg::S_INSERT: begin
				if (out_free) begin
					state_d = sdtw_pkg::S_IDLE;
				end
			end
			sdtw_pkg::S_TICK_HEAD: begin
				if (head_ok) begin
					state_d = sdtw_pkg::S_WALK;
				end else if (out_free) begin
					state_d = sdtw_pkg::S_IDLE;
				end
			end
			sdtw_pkg::S_WALK: begin
				if (out_free && walk_last) begin
					state_d = sdtw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sdtw_pkg::S_IDLE;
			end
		endcase
	end

	// Output logic: memory strobes, divider start and the next result word.
	always_comb begin
		slot_we = 1'b0;
		slot_waddr = cur_q;
		slot_wdata = sdtw_pkg::PTR_NULL;
		slot_re = 1'b0;
		slot_raddr = cur_q;
		ev_we = '0;
		ev_waddr = e_q;
		ev_wdata.next = slot_rdata;
		ev_wdata.target = in_q.target_id;
		ev_wdata.handler = in_q.handler_sel;
		ev_re = 1'b0;
		ev_raddr = e_q;
		div_start = 1'b0;
		out_load = 1'b0;
		out_next = '0;
		out_next.status = sdtw_pkg::ST_OK;
		out_next.last = 1'b1;
		case (state_q)
			sdtw_pkg::S_CLEAR: begin
				slot_we = 1'b1;
				slot_waddr = clr_q;
			end
			sdtw_pkg::S_IDLE: begin
				if (in_fire) begin
					if (in_data.kind == sdtw_pkg::KIND_TICK) begin
						slot_re = 1'b1;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			sdtw_pkg::S_ALLOC: begin
				if (over_q) begin
					out_load = out_free;
					out_next.status = sdtw_pkg::ST_TOO_LONG;
				end else if (recycle_ok || fresh_ok) begin
					slot_re = 1'b1;
					slot_raddr = slot_q;
					ev_re = recycle_ok;
					ev_raddr = recycle_q[EV_W-1:0];
				end else begin
					out_load = out_free;
					out_next.status = sdtw_pkg::ST_POOL_FULL;
				end
			end
			sdtw_pkg::S_INSERT: begin
				if (out_free) begin
					out_load = 1'b1;
					ev_we.entry = 1'b1;
					slot_we = 1'b1;
					slot_waddr = slot_q;
					slot_wdata = sdtw_pkg::PTR_W'(e_q);
				end
			end
			sdtw_pkg::S_TICK_HEAD: begin
				if (head_ok) begin
					ev_re = 1'b1;
					ev_raddr = slot_rdata[EV_W-1:0];
				end else if (out_free) begin
					out_load = 1'b1;
					slot_we = 1'b1;
				end
			end
			sdtw_pkg::S_WALK: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.event_valid = 1'b1;
					out_next.out_target = ev_rdata.target;
					out_next.out_handler = ev_rdata.handler;
					out_next.last = walk_last;
					if (walk_last) begin
						// Splice the drained list in front of the recycle list.
						ev_we.link = 1'b1;
						ev_wdata.next = recycle_q;
						slot_we = 1'b1;
					end else begin
						ev_re = 1'b1;
						ev_raddr = ev_rdata.next[EV_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtw_pkg::S_CLEAR;
			clr_q <= '0;
			cur_q <= '0;
			recycle_q <= sdtw_pkg::PTR_NULL;
			fresh_q <= '0;
			out_valid_q <= 1'b0;
			ring_len_q <= sdtw_pkg::RING_LEN_W'(256);
			step_q <= sdtw_pkg::STEP_W'(100);
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == sdtw_pkg::CFG_RING_LENGTH) begin
					ring_len_q <= cfg_data[sdtw_pkg::RING_LEN_W-1:0];
				end else if (cfg_index == sdtw_pkg::CFG_STEP_TIME) begin
					step_q <= cfg_data;
				end
			end
			if (state_q == sdtw_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == sdtw_pkg::S_INSERT) && out_free) begin
				if (from_recycle_q) begin
					recycle_q <= ev_rdata.next;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if ((state_q == sdtw_pkg::S_TICK_HEAD) && !head_ok && out_free) begin
				cur_q <= cur_next;
			end
			if ((state_q == sdtw_pkg::S_WALK) && out_free && walk_last) begin
				recycle_q <= head_q;
				cur_q <= cur_next;
			end
		end
	end

	// Working registers of the word in flight.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_data;
		end
		if (state_q == sdtw_pkg::S_SLOT) begin
			over_q <= (slot_wrap >= len_eff);
			slot_q <= slot_wrap[CUR_W-1:0];
		end
		if ((state_q == sdtw_pkg::S_ALLOC) && !over_q) begin
			from_recycle_q <= recycle_ok;
			e_q <= recycle_ok ? recycle_q[EV_W-1:0] : fresh_q[EV_W-1:0];
		end
		if ((state_q == sdtw_pkg::S_TICK_HEAD) && head_ok) begin
			head_q <= slot_rdata;
			e_q <= slot_rdata[EV_W-1:0];
			n_q <= '0;
		end
		if ((state_q == sdtw_pkg::S_WALK) && out_free && !walk_last) begin
			e_q <= ev_rdata.next[EV_W-1:0];
			n_q <= n_q + 1'b1;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// In the final walk step e_q is the tail of the drained list.
	sdtw_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	sdtw_slot_ram #(
		.DEPTH (RING_MAX),
		.AW    (CUR_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	sdtw_event_ram #(
		.DEPTH (POOL_SIZE),
		.AW    (EV_W)
	) u_event_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.re    (ev_re),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
